@@ src/assert_macros.svh @@
// Assertion macros used by the reader RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define EGBR_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define EGBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/egbr_pkg.sv @@
// Constants and command codes of the Exp-Golomb bit reader.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package egbr_pkg;

   localparam int MAX_BYTES = 4096;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int COUNT_W   = ADDR_W + 1;
   localparam int POS_W     = COUNT_W + 3;

   localparam int CMD_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int FIELD_W   = 6;
   localparam int VALUE_W   = 33;
   localparam int OUT_POS_W = 16;
   localparam int WORD_W    = 32;
   localparam int WIN_BYTES = 5;
   localparam int WIN_W     = WIN_BYTES * BYTE_W;
   localparam int STEP_W    = $clog2(WIN_BYTES + 1);

   localparam logic [FIELD_W-1:0] LZ_LIMIT = FIELD_W'(31);

   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ_UE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_SE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_MORE    = 3'd5;

endpackage

`default_nettype wire

@@ src/egbr_req_if.sv @@
// Command channel of the Exp-Golomb bit reader: valid/ready plus payload.
// Depends on egbr_pkg.
`default_nettype none

interface egbr_req_if;
   logic                           valid;
   logic                           ready;
   logic [egbr_pkg::CMD_W-1:0]     command;
   logic [egbr_pkg::BYTE_W-1:0]    data_byte;
   logic [egbr_pkg::FIELD_W-1:0]   field_bits;

   modport source (output valid, command, data_byte, field_bits, input ready);
   modport sink   (input valid, command, data_byte, field_bits, output ready);
endinterface

`default_nettype wire

@@ src/egbr_rsp_if.sv @@
// Result channel of the Exp-Golomb bit reader: valid/ready plus payload.
// Depends on egbr_pkg.
`default_nettype none

interface egbr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [egbr_pkg::VALUE_W-1:0] value;
   logic                               more_data;
   logic                               error;
   logic [egbr_pkg::OUT_POS_W-1:0]     bit_position;
   logic [egbr_pkg::OUT_POS_W-1:0]     bits_left;

   modport source (output valid, value, more_data, error, bit_position, bits_left,
                   input ready);
   modport sink   (input valid, value, more_data, error, bit_position, bits_left,
                   output ready);
endinterface

`default_nettype wire

@@ src/exp_golomb_bit_reader.sv @@
// Exp-Golomb bit reader: byte payload memory, window fetch and decode sequencer.
// Depends on egbr_pkg, egbr_req_if, egbr_rsp_if and assert_macros.svh.
//
// Usage: commands arrive on req_ch (valid/ready); each gives one transfer on
// rsp_ch. Restart clears count, offset and error; load appends data_byte to
// the payload memory; read, ue and se decode MSB-first from the read offset;
// the more-data query scans the payload for the stop bit.
// Restart, load and unused codes go straight to the output register. A fixed
// read fetches one 5-byte window, one memory read per cycle; ue and se fetch
// a prefix window, then a suffix window; the more-data query reads bytes from
// the end backward until it finds a nonzero byte or reaches the read offset.
// The payload memory has a single registered read port: each window takes
// five reads.
// A new command is taken once the previous one has reached the output
// register, so it overlaps a result that is still waiting. When rsp_ch stalls
// the finished result holds and the sequencer waits for the slot.
// Reset (synchronous) empties the buffer and clears offset and error; memory
// contents are not cleared, and only bytes loaded since restart are read.
`default_nettype none

`include "assert_macros.svh"

module exp_golomb_bit_reader (
   input  wire logic   clock,
   input  wire logic   reset,
   egbr_req_if.sink    req_ch,
   egbr_rsp_if.source  rsp_ch
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_FETCH,
      ST_FIX_DONE,
      ST_UE_CLZ,
      ST_UE_PFX,
      ST_MAP,
      ST_Q_ISSUE,
      ST_Q_CHECK,
      ST_FINISH
   } state_type;

   localparam int ADDR_W    = egbr_pkg::ADDR_W;
   localparam int COUNT_W   = egbr_pkg::COUNT_W;
   localparam int POS_W     = egbr_pkg::POS_W;
   localparam int BYTE_W    = egbr_pkg::BYTE_W;
   localparam int FIELD_W   = egbr_pkg::FIELD_W;
   localparam int VALUE_W   = egbr_pkg::VALUE_W;
   localparam int WORD_W    = egbr_pkg::WORD_W;
   localparam int WIN_W     = egbr_pkg::WIN_W;
   localparam int STEP_W    = egbr_pkg::STEP_W;
   localparam int OUT_POS_W = egbr_pkg::OUT_POS_W;

   state_type                  state_ff;
   logic [egbr_pkg::CMD_W-1:0] cmd_ff;
   logic [FIELD_W-1:0]         nbits_ff;
   logic                       sfx_ff;
   logic [COUNT_W-1:0]         byte_count_ff;
   logic [POS_W-1:0]           offset_ff;
   logic                       error_ff;
   logic [WIN_W-1:0]           win_ff;
   logic [2:0]                 sel_ff;
   logic [COUNT_W-1:0]         fidx_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       rng_ff;
   logic [BYTE_W-1:0]          rd_ff;
   logic [FIELD_W-1:0]         lz_ff;
   logic [VALUE_W-1:0]         value_ff;
   logic                       more_ff;
   logic [COUNT_W-1:0]         scan_ff;

   logic                       rsp_valid_ff;
   logic [VALUE_W-1:0]         rsp_value_ff;
   logic                       rsp_more_ff;
   logic                       rsp_error_ff;
   logic [OUT_POS_W-1:0]       rsp_pos_ff;
   logic [OUT_POS_W-1:0]       rsp_left_ff;

   logic [BYTE_W-1:0]          mem [egbr_pkg::MAX_BYTES];

   logic                       accept;
   logic                       wr_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [POS_W-1:0]           total;
   logic [POS_W-1:0]           avail;
   logic [WIN_W-1:0]           win_shift;
   logic [WORD_W-1:0]          win_word;
   logic [FIELD_W-1:0]         fix_m;
   logic [WORD_W-1:0]          fix_val;
   logic [POS_W-1:0]           fetch_start;
   logic [POS_W-1:0]           n_ext;
   logic                       short;
   logic [POS_W-1:0]           lz_ext;
   logic [FIELD_W-1:0]         zz;
   logic [COUNT_W-1:0]         obyte;
   logic [BYTE_W-1:0]          q_mask;
   logic [VALUE_W-1:0]         code1;
   logic [VALUE_W-1:0]         mag;

   function automatic logic [FIELD_W-1:0] count_lz(input logic [WORD_W-1:0] w);
      logic [FIELD_W-1:0] n;
      n = FIELD_W'(WORD_W);
      for (int i = 0; i < WORD_W; i++) begin
         if (w[i]) begin
            n = FIELD_W'(WORD_W - 1 - i);
         end
      end
      return n;
   endfunction

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign wr_en   = accept && (req_ch.command == egbr_pkg::CMD_LOAD) &&
                    (byte_count_ff < COUNT_W'(egbr_pkg::MAX_BYTES));
   assign rd_addr = (state_ff == ST_Q_ISSUE) ? scan_ff[ADDR_W-1:0] : fidx_ff[ADDR_W-1:0];

   always_comb begin
      total       = {byte_count_ff, 3'b000};
      avail       = total - offset_ff;
      win_shift   = win_ff << sel_ff;
      win_word    = win_shift[WIN_W-1 -: WORD_W];
      fix_m       = (nbits_ff > FIELD_W'(WORD_W)) ? FIELD_W'(WORD_W) : nbits_ff;
      fix_val     = win_word >> (FIELD_W'(WORD_W) - fix_m);
      n_ext       = POS_W'(nbits_ff);
      fetch_start = offset_ff + n_ext - POS_W'(fix_m);
      short       = n_ext > avail;
      lz_ext      = POS_W'(lz_ff);
      zz          = (avail < lz_ext) ? avail[FIELD_W-1:0] : lz_ff;
      obyte       = offset_ff[POS_W-1:3];
      q_mask      = 8'h7F >> offset_ff[2:0];
      // code + 1 = 2^z + suffix, suffix < 2^z
      code1       = (VALUE_W'(1) << nbits_ff) | {1'b0, value_ff[WORD_W-1:0]};
      mag         = code1 >> 1;
   end

   // payload memory: write on load below capacity, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[byte_count_ff[ADDR_W-1:0]] <= req_ch.data_byte;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         byte_count_ff <= '0;
         offset_ff     <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req_ch.command;
                  value_ff <= '0;
                  more_ff  <= 1'b0;
                  sfx_ff   <= 1'b0;
                  case (req_ch.command)
                     egbr_pkg::CMD_RESTART: begin
                        byte_count_ff <= '0;
                        offset_ff     <= '0;
                        error_ff      <= 1'b0;
                        state_ff      <= ST_FINISH;
                     end
                     egbr_pkg::CMD_LOAD: begin
                        if (wr_en) begin
                           byte_count_ff <= byte_count_ff + 1'b1;
                        end else begin
                           error_ff <= 1'b1;
                        end
                        state_ff <= ST_FINISH;
                     end
                     egbr_pkg::CMD_READ: begin
                        nbits_ff <= req_ch.field_bits;
                        state_ff <= ST_LAUNCH;
                     end
                     egbr_pkg::CMD_READ_UE, egbr_pkg::CMD_READ_SE: begin
                        nbits_ff <= '0;
                        state_ff <= ST_LAUNCH;
                     end
                     egbr_pkg::CMD_MORE: begin
                        if (obyte < byte_count_ff) begin
                           scan_ff  <= byte_count_ff - 1'b1;
                           state_ff <= ST_Q_ISSUE;
                        end else begin
                           state_ff <= ST_FINISH;
                        end
                     end
                     default: begin
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_LAUNCH: begin
               fidx_ff  <= fetch_start[POS_W-1:3];
               sel_ff   <= fetch_start[2:0];
               step_ff  <= '0;
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               // issue five byte reads; each read's data arrives in the cycle after its issue
               if (step_ff < STEP_W'(egbr_pkg::WIN_BYTES)) begin
                  fidx_ff <= fidx_ff + 1'b1;
                  rng_ff  <= fidx_ff < byte_count_ff;
               end
               if (step_ff != '0) begin
                  win_ff <= {win_ff[WIN_W-BYTE_W-1:0], rng_ff ? rd_ff : '0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(egbr_pkg::WIN_BYTES)) begin
                  if (cmd_ff == egbr_pkg::CMD_READ || sfx_ff) begin
                     state_ff <= ST_FIX_DONE;
                  end else begin
                     state_ff <= ST_UE_CLZ;
                  end
               end
            end
            ST_FIX_DONE: begin
               value_ff  <= {1'b0, fix_val};
               offset_ff <= offset_ff + (short ? avail : n_ext);
               if (short) begin
                  error_ff <= 1'b1;
               end
               state_ff <= (cmd_ff == egbr_pkg::CMD_READ) ? ST_FINISH : ST_MAP;
            end
            ST_UE_CLZ: begin
               lz_ff    <= count_lz(win_word);
               state_ff <= ST_UE_PFX;
            end
            ST_UE_PFX: begin
               if (zz >= egbr_pkg::LZ_LIMIT) begin
                  offset_ff <= offset_ff + POS_W'(egbr_pkg::LZ_LIMIT);
                  error_ff  <= 1'b1;
                  nbits_ff  <= '0;
               end else if (lz_ext < avail) begin
                  offset_ff <= offset_ff + lz_ext + 1'b1;
                  nbits_ff  <= lz_ff;
               end else begin
                  offset_ff <= offset_ff + POS_W'(zz);
                  nbits_ff  <= zz;
               end
               sfx_ff   <= 1'b1;
               state_ff <= ST_LAUNCH;
            end
            ST_MAP: begin
               if (cmd_ff == egbr_pkg::CMD_READ_UE) begin
                  value_ff <= code1 - 1'b1;
               end else begin
                  value_ff <= code1[0] ? (VALUE_W'(0) - mag) : mag;
               end
               state_ff <= ST_FINISH;
            end
            ST_Q_ISSUE: begin
               state_ff <= ST_Q_CHECK;
            end
            ST_Q_CHECK: begin
               if (scan_ff == obyte) begin
                  more_ff  <= (rd_ff & q_mask) != '0;
                  state_ff <= ST_FINISH;
               end else if (rd_ff != '0) begin
                  more_ff  <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  scan_ff  <= scan_ff - 1'b1;
                  state_ff <= ST_Q_ISSUE;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= value_ff;
                  rsp_more_ff  <= more_ff;
                  rsp_error_ff <= error_ff;
                  rsp_pos_ff   <= OUT_POS_W'(offset_ff);
                  rsp_left_ff  <= OUT_POS_W'(avail);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.value        = rsp_value_ff;
   assign rsp_ch.more_data    = rsp_more_ff;
   assign rsp_ch.error        = rsp_error_ff;
   assign rsp_ch.bit_position = rsp_pos_ff;
   assign rsp_ch.bits_left    = rsp_left_ff;

   `EGBR_ASSERT_HOLDS(a_offset_bound, clock, reset, offset_ff <= total, "offset past data")
   `EGBR_ASSERT_HOLDS(a_count_bound, clock, reset,
      byte_count_ff <= COUNT_W'(egbr_pkg::MAX_BYTES), "byte count overflow")
   `EGBR_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, state_ff != ST_IDLE,
      "idle after transfer")
   `EGBR_ASSERT_NEXT(a_error_sticky, clock, reset,
      error_ff && !(accept && req_ch.command == egbr_pkg::CMD_RESTART), error_ff,
      "error flag dropped")
   `EGBR_ASSERT_NEXT(a_fetch_len, clock, reset,
      state_ff == ST_FETCH && step_ff == STEP_W'(egbr_pkg::WIN_BYTES),
      state_ff == ST_FIX_DONE || state_ff == ST_UE_CLZ, "window fetch length")

endmodule

`default_nettype wire

@@ tb/exp_golomb_bit_reader_tb.sv @@
// Self-checking testbench of exp_golomb_bit_reader: directed command table and random
// RBSP sequences, each checked against its table entry or an in-bench reader model.
// Depends on egbr_pkg, egbr_req_if, egbr_rsp_if and the exp_golomb_bit_reader RTL.
module exp_golomb_bit_reader_tb;

   localparam logic [egbr_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd6;
   localparam logic [egbr_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd7;
   localparam int MAX_GAP      = 12;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 50;
   localparam int RANDOM_ITEMS = 1080;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic [egbr_pkg::CMD_W-1:0]   command;
      logic [egbr_pkg::BYTE_W-1:0]  data_byte;
      logic [egbr_pkg::FIELD_W-1:0] field_bits;
   } cmd_type;

   typedef struct packed {
      logic [egbr_pkg::VALUE_W-1:0]   value;
      logic                           more_data;
      logic                           error;
      logic [egbr_pkg::OUT_POS_W-1:0] bit_position;
      logic [egbr_pkg::OUT_POS_W-1:0] bits_left;
   } result_type;

   typedef struct {
      cmd_type    item;
      bit         typed;
      result_type want;
   } row_type;

   logic clock;
   logic reset;

   egbr_req_if req_ch ();
   egbr_rsp_if rsp_ch ();

   exp_golomb_bit_reader DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // reader model state
   logic [egbr_pkg::BYTE_W-1:0] pl_mem [egbr_pkg::MAX_BYTES];
   int unsigned                 pl_count;
   int unsigned                 rd_off;
   bit                          sticky_err;

   result_type  predicted_results [$];
   row_type     script [$];
   int          mismatches;
   int unsigned accepted_items;
   int unsigned cycle_count;
   bit          no_idle;
   bit          hold_results;

   function automatic bit bit_of(int unsigned pos);
      return pl_mem[pos >> 3][7 - (pos & 7)];
   endfunction

   function automatic bit pull_bit();
      if (rd_off >= pl_count * 8) begin
         sticky_err = 1'b1;
         return 1'b0;
      end
      pull_bit = bit_of(rd_off);
      rd_off++;
   endfunction

   function automatic logic [egbr_pkg::WORD_W-1:0] pull_field(int unsigned n);
      logic [egbr_pkg::WORD_W-1:0] v;
      v = '0;
      for (int unsigned i = 0; i < n; i++)
         v = {v[egbr_pkg::WORD_W-2:0], pull_bit()};
      return v;
   endfunction

   function automatic logic [egbr_pkg::WORD_W-1:0] pull_ue();
      int unsigned zeros;
      zeros = 0;
      while (rd_off < pl_count * 8) begin
         if (pull_bit())
            break;
         zeros++;
         if (zeros >= egbr_pkg::LZ_LIMIT) begin
            sticky_err = 1'b1;
            return '0;
         end
      end
      if (zeros == 0)
         return '0;
      return ((egbr_pkg::WORD_W'(1) << zeros) - egbr_pkg::WORD_W'(1)) + pull_field(zeros);
   endfunction

   // 1 when the last 1 bit (the stop bit) lies after the offset
   function automatic bit stop_bit_follows();
      for (int unsigned p = pl_count * 8; p > rd_off; p--)
         if (bit_of(p - 1))
            return (p - 1) > rd_off;
      return 1'b0;
   endfunction

   function automatic result_type decode_predict(cmd_type c);
      result_type                   r;
      logic [egbr_pkg::WORD_W-1:0]  code;
      logic [egbr_pkg::VALUE_W-1:0] mag;
      r = '0;
      case (c.command)
         egbr_pkg::CMD_RESTART: begin
            pl_count   = 0;
            rd_off     = 0;
            sticky_err = 1'b0;
         end
         egbr_pkg::CMD_LOAD: begin
            if (pl_count >= egbr_pkg::MAX_BYTES)
               sticky_err = 1'b1;
            else begin
               pl_mem[pl_count] = c.data_byte;
               pl_count++;
            end
         end
         egbr_pkg::CMD_READ:    r.value = {1'b0, pull_field(c.field_bits)};
         egbr_pkg::CMD_READ_UE: r.value = {1'b0, pull_ue()};
         egbr_pkg::CMD_READ_SE: begin
            code = pull_ue();
            mag = ({1'b0, code} + egbr_pkg::VALUE_W'(1)) >> 1;
            r.value = code[0] ? mag : -mag;
         end
         egbr_pkg::CMD_MORE: r.more_data = stop_bit_follows();
         default: ;
      endcase
      r.error        = sticky_err;
      r.bit_position = egbr_pkg::OUT_POS_W'(rd_off);
      r.bits_left    = egbr_pkg::OUT_POS_W'(pl_count * 8 - rd_off);
      return r;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [egbr_pkg::BYTE_W-1:0] draw_byte();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         2:       return egbr_pkg::BYTE_W'($urandom_range(1, 15));
         default: return egbr_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [egbr_pkg::FIELD_W-1:0] draw_width();
      if ($urandom_range(0, 5) == 0)
         return egbr_pkg::FIELD_W'($urandom_range(33, 63));
      return egbr_pkg::FIELD_W'($urandom_range(0, 32));
   endfunction

   function automatic void add_row(logic [egbr_pkg::CMD_W-1:0] cmd,
                                   logic [egbr_pkg::BYTE_W-1:0] dbyte = '0,
                                   logic [egbr_pkg::FIELD_W-1:0] nbits = '0,
                                   bit typed = 1'b0,
                                   logic [egbr_pkg::VALUE_W-1:0] v = '0,
                                   bit md = 1'b0, bit er = 1'b0,
                                   logic [egbr_pkg::OUT_POS_W-1:0] pos = '0,
                                   logic [egbr_pkg::OUT_POS_W-1:0] left = '0);
      row_type r;
      r.item.command      = cmd;
      r.item.data_byte    = dbyte;
      r.item.field_bits   = nbits;
      r.typed             = typed;
      r.want.value        = v;
      r.want.more_data    = md;
      r.want.error        = er;
      r.want.bit_position = pos;
      r.want.bits_left    = left;
      script.push_back(r);
   endfunction

   // valid stays high after a transfer when the next gap is zero
   task automatic issue(input logic [egbr_pkg::CMD_W-1:0] cmd,
                        input logic [egbr_pkg::BYTE_W-1:0] dbyte = '0,
                        input logic [egbr_pkg::FIELD_W-1:0] nbits = '0,
                        input bit typed = 1'b0,
                        input result_type want = '0);
      cmd_type    item;
      result_type pred;
      int         gap;
      item.command    = cmd;
      item.data_byte  = dbyte;
      item.field_bits = nbits;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.data_byte  <= dbyte;
      req_ch.field_bits <= nbits;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pred = decode_predict(item);
      predicted_results.push_back(typed ? want : pred);
      if (cmd <= egbr_pkg::CMD_MORE)
         accepted_items++;
   endtask

   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (predicted_results.size() != 0);
   endtask

   task automatic random_sequence();
      int nbytes;
      int pick;
      if (pl_count > 192 || $urandom_range(0, 4) != 0)
         issue(egbr_pkg::CMD_RESTART, draw_byte(), draw_width());
      nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      repeat (nbytes) issue(egbr_pkg::CMD_LOAD, draw_byte(), draw_width());
      repeat ($urandom_range(2, 14)) begin
         pick = $urandom_range(0, 99);
         if (pick < 25)
            issue(egbr_pkg::CMD_READ, draw_byte(), draw_width());
         else if (pick < 50)
            issue(egbr_pkg::CMD_READ_UE, draw_byte(), draw_width());
         else if (pick < 70)
            issue(egbr_pkg::CMD_READ_SE, draw_byte(), draw_width());
         else if (pick < 85)
            issue(egbr_pkg::CMD_MORE, draw_byte(), draw_width());
         else if (pick < 92)
            issue(egbr_pkg::CMD_LOAD, draw_byte(), draw_width());
         else if (pick < 97)
            issue(pick[0] ? CMD_UNUSED_A : CMD_UNUSED_B, draw_byte(), draw_width());
         else
            issue(egbr_pkg::CMD_RESTART, draw_byte(), draw_width());
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL exp_golomb_bit_reader");
         $finish;
      end
   end

   // result side: random stalls, one long hold on request, field checks
   initial begin : result_sink
      result_type got;
      result_type want;
      int         stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = hold_results ? LONG_HOLD : draw_gap();
         hold_results = 1'b0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.value        = rsp_ch.value;
         got.more_data    = rsp_ch.more_data;
         got.error        = rsp_ch.error;
         got.bit_position = rsp_ch.bit_position;
         got.bits_left    = rsp_ch.bits_left;
         if (predicted_results.size() == 0) begin
            $error("result transfer with no command outstanding");
            mismatches++;
         end else begin
            want = predicted_results.pop_front();
            if (got.value !== want.value) begin
               $error("value: expected %h, got %h", want.value, got.value);
               mismatches++;
            end
            if (got.more_data !== want.more_data) begin
               $error("more_data: expected %b, got %b", want.more_data, got.more_data);
               mismatches++;
            end
            if (got.error !== want.error) begin
               $error("error: expected %b, got %b", want.error, got.error);
               mismatches++;
            end
            if (got.bit_position !== want.bit_position) begin
               $error("bit_position: expected %0d, got %0d",
                      want.bit_position, got.bit_position);
               mismatches++;
            end
            if (got.bits_left !== want.bits_left) begin
               $error("bits_left: expected %0d, got %0d", want.bits_left, got.bits_left);
               mismatches++;
            end
         end
      end
   end

   initial begin : command_source
      int unsigned random_start;
      bit          hold_done;
      bit          drain_done;
      mismatches        = 0;
      accepted_items    = 0;
      cycle_count       = 0;
      no_idle           = 1'b0;
      hold_results      = 1'b0;
      hold_done         = 1'b0;
      drain_done        = 1'b0;
      pl_count          = 0;
      rd_off            = 0;
      sticky_err        = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= egbr_pkg::CMD_RESTART;
      req_ch.data_byte  <= '0;
      req_ch.field_bits <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty buffer
      add_row(egbr_pkg::CMD_MORE, 8'h00, 6'd0, 1'b1, '0, 1'b0, 1'b0, 16'd0, 16'd0);
      add_row(egbr_pkg::CMD_READ_UE, 8'h00, 6'd0, 1'b1, '0, 1'b0, 1'b0, 16'd0, 16'd0);
      add_row(egbr_pkg::CMD_READ, 8'h00, 6'd0, 1'b1, '0, 1'b0, 1'b0, 16'd0, 16'd0);
      add_row(egbr_pkg::CMD_LOAD, 8'hFF, 6'd0, 1'b1, '0, 1'b0, 1'b0, 16'd0, 16'd8);
      add_row(egbr_pkg::CMD_LOAD, 8'h00, 6'd0, 1'b1, '0, 1'b0, 1'b0, 16'd0, 16'd16);
      add_row(egbr_pkg::CMD_READ, 8'h00, 6'd1, 1'b1, 33'd1, 1'b0, 1'b0, 16'd1, 16'd15);
      add_row(egbr_pkg::CMD_READ_SE);
      add_row(egbr_pkg::CMD_READ_UE);
      add_row(egbr_pkg::CMD_MORE);
      add_row(egbr_pkg::CMD_READ, 8'h00, 6'd4);
      // offset now on the stop bit
      add_row(egbr_pkg::CMD_MORE);
      add_row(CMD_UNUSED_A, 8'hFF, 6'd63);
      add_row(CMD_UNUSED_B, 8'h80, 6'd32);
      // wider than 32, runs past the end
      add_row(egbr_pkg::CMD_READ, 8'h00, 6'd40);
      add_row(egbr_pkg::CMD_RESTART, 8'h00, 6'd0, 1'b1, '0, 1'b0, 1'b0, 16'd0, 16'd0);
      repeat (4) add_row(egbr_pkg::CMD_LOAD, 8'h00);
      // 32 zero bits hit the limit of 31 leading zeros
      add_row(egbr_pkg::CMD_READ_UE, 8'h00, 6'd0, 1'b1, '0, 1'b0, 1'b1, 16'd31, 16'd1);
      add_row(egbr_pkg::CMD_RESTART, 8'h00, 6'd0, 1'b1, '0, 1'b0, 1'b0, 16'd0, 16'd0);
      // suffix runs out after the prefix
      add_row(egbr_pkg::CMD_LOAD, 8'h01);
      add_row(egbr_pkg::CMD_READ_SE);
      add_row(egbr_pkg::CMD_RESTART);
      // code 4 gives -2
      add_row(egbr_pkg::CMD_LOAD, 8'h28);
      add_row(egbr_pkg::CMD_READ_SE);
      add_row(egbr_pkg::CMD_LOAD, 8'hFF);
      add_row(egbr_pkg::CMD_READ, 8'h00, 6'd32);
      foreach (script[i])
         issue(script[i].item.command, script[i].item.data_byte, script[i].item.field_bits,
               script[i].typed, script[i].want);
      pause_until_drained();

      random_start = accepted_items;
      while (accepted_items - random_start < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if (!hold_done && accepted_items - random_start >= 300) begin
            hold_results = 1'b1;
            hold_done    = 1'b1;
         end
         if (!drain_done && accepted_items - random_start >= 650) begin
            pause_until_drained();
            drain_done = 1'b1;
         end
         random_sequence();
      end

      pause_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS exp_golomb_bit_reader");
      else
         $display("FAIL exp_golomb_bit_reader");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/egbr_pkg.sv
src/egbr_req_if.sv
src/egbr_rsp_if.sv
src/exp_golomb_bit_reader.sv
tb/exp_golomb_bit_reader_tb.sv
